/* hw/rtl/cca_pkg.sv */
`timescale 1ns / 1ps

package cca_pkg;

  localparam int unsigned DefChannels    = 32;
  localparam int unsigned DefCorrelators = 8;

  localparam int unsigned HalfW     = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned MaskW     = 32;
  localparam int unsigned ChanW     = 5;
  localparam int unsigned CorW      = 3;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned WordBase  = 24;
  localparam logic [AddrW-1:0] AddrMask = 12'hfff;

  // action codes
  localparam logic ActBlockStart = 1'b0;
  localparam logic ActDump       = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [ChanW-1:0]         channel;
    logic [CorW-1:0]          correlator;
    logic                     first_epoch;
    logic                     protect;
    logic signed [HalfW-1:0]  dump_i;
    logic signed [HalfW-1:0]  dump_q;
  } cca_in_t;

  typedef struct packed {
    logic signed [HalfW-1:0]  sum_i;
    logic signed [HalfW-1:0]  sum_q;
    logic                     stored;
    logic [MaskW-1:0]         protect_mask;
    logic [AddrW-1:0]         protect_address;
    logic [WordW-1:0]         protect_value;
    logic [CorW-1:0]          next_correlator;
  } cca_out_t;

  // byte address of the accumulator word: ((ch * 32) + 24 + cor) * 4
  function automatic logic [AddrW-1:0] prot_addr(logic [ChanW-1:0] ch,
                                                 logic [CorW-1:0]  cor);
    logic [AddrW+1:0] full;
    full = ((AddrW+2)'(ch) << 5) + (AddrW+2)'(WordBase) + (AddrW+2)'(cor);
    return (AddrW)'(full << 2) & AddrMask;
  endfunction

endpackage

/* hw/rtl/cca_store.sv */
`timescale 1ns / 1ps

module cca_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned SLOT_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [SLOT_W-1:0]          rd_slot_i,
  input  logic                       wr_en_i,
  input  logic [SLOT_W-1:0]          wr_slot_i,
  input  logic [cca_pkg::WordW-1:0]  wr_data_i,
  output logic [cca_pkg::WordW-1:0]  rd_word_o
);
  import cca_pkg::*;

  logic [WordW-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;

  logic [WordW-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_slot_q;

  // last write, covers a write that lands at or after the read
  logic              fwd_vld_q;
  logic [SLOT_W-1:0] fwd_slot_q;
  logic [WordW-1:0]  fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_slot_i];
      rd_slot_q <= rd_slot_i;
    end
    if (wr_en_i) begin
      fwd_slot_q <= wr_slot_i;
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_slot_i] <= 1'b1;
        fwd_vld_q        <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_slot_i];
      end
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_slot_q == rd_slot_q)) begin
      rd_word_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_word_o = rd_data_q;
    end else begin
      rd_word_o = '0;
    end
  end

endmodule

/* hw/rtl/coherent_correlator_accumulator.sv */
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   in_data_i   (cca_in_t)
// out      out_valid_o/out_ready_i out_data_o  (cca_out_t)
// cfg      cfg_we_i                cfg_wdata_i (channel enable mask)
//
// One transaction per cycle sustained while the output is not stalled; the result
// register loads when the compute stage commits. The accumulator RAM is read at
// acceptance and written back at commit; forwarding covers back-to-back same-word hits.
// Reset zeroes the store through per-word valid bits, so no clearing pass is needed.
// A stalled output holds the pending transaction in the compute stage.

module coherent_correlator_accumulator #(
  parameter int unsigned CHANNELS    = cca_pkg::DefChannels,
  parameter int unsigned CORRELATORS = cca_pkg::DefCorrelators
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cca_pkg::cca_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output cca_pkg::cca_out_t       out_data_o,
  input  logic                    cfg_we_i,
  input  logic [cca_pkg::MaskW-1:0] cfg_wdata_i
);
  import cca_pkg::*;

  localparam int unsigned Depth  = CHANNELS * CORRELATORS;
  localparam int unsigned SlotW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PtrIdW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [MaskW-1:0]  chan_en_q;
  logic              s1_vld_q;
  cca_in_t           s1_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic              out_vld_q;
  cca_out_t          out_q;

  logic [MaskW-1:0]  pmask_q, pmask_d;
  logic [AddrW-1:0]  paddr_q, paddr_d;
  logic [WordW-1:0]  pval_q, pval_d;
  logic [CorW-1:0]   ptr_q [CHANNELS];

  logic              in_acc, commit;
  logic [SlotW-1:0]  in_slot;
  logic [WordW-1:0]  old_word, base_word;
  logic              ch_ok, cor_ok, dump_go, wr_en, ptr_upd;
  logic [PtrIdW-1:0] ptr_idx;
  logic [CorW-1:0]   ptr_cur, ptr_new;
  cca_out_t          out_d;

  assign commit     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || commit;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_slot    = SlotW'(32'(in_data_i.channel) * CORRELATORS
                             + 32'(in_data_i.correlator));

  cca_store #(
    .DEPTH  (Depth),
    .SLOT_W (SlotW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_slot_i (in_slot),
    .wr_en_i   (wr_en),
    .wr_slot_i (s1_slot_q),
    .wr_data_i ({out_d.sum_i, out_d.sum_q}),
    .rd_word_o (old_word)
  );

  assign ch_ok   = 32'(s1_q.channel) < CHANNELS;
  assign cor_ok  = 32'(s1_q.correlator) < CORRELATORS;
  assign dump_go = (s1_q.action == ActDump) && ch_ok && cor_ok
                   && chan_en_q[s1_q.channel];
  assign ptr_idx = PtrIdW'(s1_q.channel);
  assign ptr_cur = ptr_q[ptr_idx];
  assign ptr_new = s1_q.correlator + CorW'(1);
  assign base_word = s1_q.first_epoch ? '0 : old_word;
  assign wr_en   = commit && dump_go && !s1_q.protect;
  assign ptr_upd = commit && dump_go;

  always_comb begin
    pmask_d = pmask_q;
    paddr_d = paddr_q;
    pval_d  = pval_q;
    out_d   = '0;
    if (s1_q.action == ActBlockStart) begin
      pmask_d = '0;
    end else if (!dump_go) begin
      if (ch_ok) begin
        out_d.next_correlator = ptr_cur;
      end
    end else begin
      if (s1_q.protect) begin
        pmask_d[s1_q.channel] = 1'b1;
        paddr_d = prot_addr(s1_q.channel, s1_q.correlator);
        pval_d  = {s1_q.dump_i, s1_q.dump_q};
      end else begin
        out_d.sum_i  = base_word[WordW-1:HalfW] + s1_q.dump_i;
        out_d.sum_q  = base_word[HalfW-1:0] + s1_q.dump_q;
        out_d.stored = 1'b1;
      end
      out_d.next_correlator = ptr_new;
    end
    out_d.protect_mask    = pmask_d;
    out_d.protect_address = paddr_d;
    out_d.protect_value   = pval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_en_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pmask_q   <= '0;
      paddr_q   <= '0;
      pval_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        chan_en_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (commit) begin
        out_vld_q <= 1'b1;
        pmask_q   <= pmask_d;
        paddr_q   <= paddr_d;
        pval_q    <= pval_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (ptr_upd) begin
        ptr_q[ptr_idx] <= ptr_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= in_data_i;
      s1_slot_q <= in_slot;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // an empty compute stage never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> in_ready_o)
    else $error("input stalled with empty compute stage");

  // every committed transaction shows up in the result register
  a_commit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_vld_q)
    else $error("committed transaction missing from result register");

  // store writes only for unprotected dumps that commit
  a_write_only_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_vld_q && s1_q.action == ActDump && !s1_q.protect))
    else $error("store written outside an unprotected dump");

  // a stored result carries a pointer one past its correlator
  a_stored_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && out_d.stored |-> out_d.next_correlator == ptr_new)
    else $error("stored result with wrong next correlator");

endmodule
